### hdl/stepper_accel_ramp_macros.svh
// assertion helpers shared by the ramp generator
`ifndef STEPPER_ACCEL_RAMP_MACROS_SVH
`define STEPPER_ACCEL_RAMP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SAR_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("ramp generator check failed");

// next-cycle implication, disabled during reset
`define SAR_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("ramp generator sequencing check failed");

`endif

### hdl/sar_pkg.sv
package sar_pkg;

   typedef enum logic [1:0] {
      MS_IDLE   = 2'd0,
      MS_UP     = 2'd1,
      MS_CRUISE = 2'd2,
      MS_DOWN   = 2'd3
   } motor_state_type;

   localparam logic [1:0] OP_STEP  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   localparam logic [15:0] START_INTERVAL_RESET = 16'd10000;
   localparam logic [15:0] TOP_INTERVAL_RESET   = 16'd10;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_stat_type;

endpackage

### hdl/sar_req_if.sv
interface sar_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] target_interval;

   modport source (output valid, opcode, target_interval, input ready);
   modport sink   (input valid, opcode, target_interval, output ready);
endinterface

### hdl/sar_rsp_if.sv
interface sar_rsp_if;
   logic        valid;
   logic        ready;
   logic        step_pulse;
   logic [15:0] next_interval;
   logic [1:0]  motor_state;
   logic        stopped;

   modport source (output valid, step_pulse, next_interval, motor_state, stopped,
                   input ready);
   modport sink   (input valid, step_pulse, next_interval, motor_state, stopped,
                   output ready);
endinterface

### hdl/stepper_accel_ramp.sv
// stepper_accel_ramp: trapezoidal ramp generator for one stepper channel
// req channel: opcode (step event, start, stop) plus target_interval for start.
// rsp channel: one transaction per req transaction, carrying step_pulse,
//   next_interval (timer compare value), motor_state and stopped.
// csr_we/csr_wdata write start_interval at any clock edge with csr_we high.
// A step event during ramp-up or ramp-down evaluates two fixed-point square
// roots on one shared bit-serial root unit, each ROOT_BITS wide, where
// ROOT_BITS = ceil((COUNT_BITS + 33) / 2) (29 at the default), then one
// 16x17 multiply and an update step; the result then passes the emit state
// into the rsp register, and req.ready returns once the sequencer is back
// in idle, so a step event is accepted only after the last one is through.
// Other transactions go straight to the emit state. The root unit's
// iteration count sets the step rate.
// req.ready is high only while the sequencer is idle; a finished result sits
// in the rsp output register, so the next req can be accepted while it waits.
// When rsp.ready is low the result holds; a following result waits in the
// sequencer until the register frees up.
// Synchronous reset: idle state, step index one, top interval 10, last and
// start interval 10000, no rsp pending. No clearing pass is needed.
module stepper_accel_ramp #(
   parameter int COUNT_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   sar_req_if.sink     req,
   sar_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   import sar_pkg::*;

   localparam int ARG_BITS  = COUNT_BITS + 1;
   localparam int RAD_BITS  = ARG_BITS + 32 + ((ARG_BITS + 32) % 2);
   localparam int ROOT_BITS = RAD_BITS / 2;

   typedef enum logic [5:0] {
      SQ_IDLE    = 6'b000001,
      SQ_ROOT_LO = 6'b000010,
      SQ_ROOT_HI = 6'b000100,
      SQ_MUL     = 6'b001000,
      SQ_UPDATE  = 6'b010000,
      SQ_EMIT    = 6'b100000
   } seq_type;

   seq_type               seq_ff, seq_in;
   motor_state_type       ramp_state_ff, ramp_state_in;
   logic [COUNT_BITS-1:0] step_index_ff, step_index_in;
   logic [15:0]           top_interval_ff, top_interval_in;
   logic [15:0]           last_interval_ff, last_interval_in;
   logic [15:0]           start_interval_ff, start_interval_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [ROOT_BITS-1:0]  s_lo_ff, s_lo_in;
   logic [16:0]           d_ff, d_in;
   logic [32:0]           prod_ff, prod_in;
   logic                  pulse_ff, pulse_in;
   logic                  done_ff, done_in;
   logic                  rsp_pulse_ff, rsp_pulse_in;
   logic [15:0]           rsp_interval_ff, rsp_interval_in;
   logic [1:0]            rsp_state_ff, rsp_state_in;
   logic                  rsp_stopped_ff, rsp_stopped_in;

   logic                  sq_start;
   logic [ARG_BITS-1:0]   sq_arg;
   logic [ROOT_BITS-1:0]  sq_root;
   sqrt_stat_type         sq_stat;
   logic [ROOT_BITS-1:0]  root_diff;
   logic [15:0]           iv;

   sar_isqrt #(.ARG_BITS(ARG_BITS)) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .arg   (sq_arg),
      .root  (sq_root),
      .stat  (sq_stat)
   );

   assign root_diff = sq_root - s_lo_ff;
   assign iv        = prod_ff[31:16];

   always_comb begin
      seq_in            = seq_ff;
      ramp_state_in     = ramp_state_ff;
      step_index_in     = step_index_ff;
      top_interval_in   = top_interval_ff;
      last_interval_in  = last_interval_ff;
      start_interval_in = csr_we ? csr_wdata : start_interval_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp.ready;
      s_lo_in           = s_lo_ff;
      d_in              = d_ff;
      prod_in           = prod_ff;
      pulse_in          = pulse_ff;
      done_in           = done_ff;
      rsp_pulse_in      = rsp_pulse_ff;
      rsp_interval_in   = rsp_interval_ff;
      rsp_state_in      = rsp_state_ff;
      rsp_stopped_in    = rsp_stopped_ff;
      sq_start          = 1'b0;
      sq_arg            = ARG_BITS'(step_index_ff);

      case (seq_ff)
         SQ_IDLE: begin
            if (req.valid) begin
               pulse_in = 1'b0;
               done_in  = 1'b0;
               seq_in   = SQ_EMIT;
               case (req.opcode)
                  OP_START: begin
                     top_interval_in = req.target_interval;
                     if (ramp_state_ff == MS_IDLE) ramp_state_in = MS_UP;
                  end
                  OP_STOP: begin
                     if (ramp_state_ff != MS_IDLE) ramp_state_in = MS_DOWN;
                  end
                  OP_STEP: begin
                     if (ramp_state_ff inside {MS_UP, MS_DOWN}) begin
                        sq_start = 1'b1;
                        seq_in   = SQ_ROOT_LO;
                     end else if (ramp_state_ff == MS_CRUISE) begin
                        pulse_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         SQ_ROOT_LO: begin
            // s(n) done, launch s(n+1)
            if (sq_stat.done) begin
               s_lo_in  = sq_root;
               sq_arg   = ARG_BITS'(step_index_ff) + ARG_BITS'(1);
               sq_start = 1'b1;
               seq_in   = SQ_ROOT_HI;
            end
         end
         SQ_ROOT_HI: begin
            if (sq_stat.done) begin
               d_in   = root_diff[16:0];
               seq_in = SQ_MUL;
            end
         end
         SQ_MUL: begin
            prod_in = 33'(start_interval_ff) * 33'(d_ff);
            seq_in  = SQ_UPDATE;
         end
         SQ_UPDATE: begin
            pulse_in = 1'b1;
            seq_in   = SQ_EMIT;
            if (ramp_state_ff == MS_UP) begin
               if (iv <= top_interval_ff) begin
                  last_interval_in = top_interval_ff;
                  ramp_state_in    = MS_CRUISE;
               end else begin
                  last_interval_in = iv;
                  if (step_index_ff != '1) step_index_in = step_index_ff + COUNT_BITS'(1);
               end
            end else begin
               if (iv >= start_interval_ff) begin
                  last_interval_in = start_interval_ff;
                  step_index_in    = COUNT_BITS'(1);
                  ramp_state_in    = MS_IDLE;
                  done_in          = 1'b1;
               end else begin
                  last_interval_in = iv;
                  if (step_index_ff != '0) step_index_in = step_index_ff - COUNT_BITS'(1);
               end
            end
         end
         SQ_EMIT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_pulse_in    = pulse_ff;
               rsp_interval_in = last_interval_ff;
               rsp_state_in    = ramp_state_ff;
               rsp_stopped_in  = done_ff;
               seq_in          = SQ_IDLE;
            end
         end
         default: seq_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff            <= SQ_IDLE;
         ramp_state_ff     <= MS_IDLE;
         step_index_ff     <= COUNT_BITS'(1);
         top_interval_ff   <= TOP_INTERVAL_RESET;
         last_interval_ff  <= START_INTERVAL_RESET;
         start_interval_ff <= START_INTERVAL_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         seq_ff            <= seq_in;
         ramp_state_ff     <= ramp_state_in;
         step_index_ff     <= step_index_in;
         top_interval_ff   <= top_interval_in;
         last_interval_ff  <= last_interval_in;
         start_interval_ff <= start_interval_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_lo_ff         <= s_lo_in;
      d_ff            <= d_in;
      prod_ff         <= prod_in;
      pulse_ff        <= pulse_in;
      done_ff         <= done_in;
      rsp_pulse_ff    <= rsp_pulse_in;
      rsp_interval_ff <= rsp_interval_in;
      rsp_state_ff    <= rsp_state_in;
      rsp_stopped_ff  <= rsp_stopped_in;
   end

   assign req.ready         = (seq_ff == SQ_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.step_pulse    = rsp_pulse_ff;
   assign rsp.next_interval = rsp_interval_ff;
   assign rsp.motor_state   = rsp_state_ff;
   assign rsp.stopped       = rsp_stopped_ff;

`include "stepper_accel_ramp_macros.svh"

   `SAR_ASSERT_NEXT(a_busy_after_req, clock, reset, req.valid && req.ready, seq_ff != SQ_IDLE)
   `SAR_ASSERT_IMPLIES(a_root_done_in_seq, clock, reset, sq_stat.done, seq_ff == SQ_ROOT_LO || seq_ff == SQ_ROOT_HI)
   `SAR_ASSERT_IMPLIES(a_stopped_is_idle, clock, reset, rsp_valid_ff && rsp_stopped_ff, rsp_state_ff == MS_IDLE && rsp_pulse_ff)
   `SAR_ASSERT_IMPLIES(a_up_index_nonzero, clock, reset, ramp_state_ff == MS_UP, step_index_ff != '0)

endmodule

### hdl/sar_isqrt.sv
module sar_isqrt #(
   parameter int ARG_BITS = 25,
   localparam int RAD_BITS = ARG_BITS + 32 + ((ARG_BITS + 32) % 2),
   localparam int ROOT_BITS = RAD_BITS / 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ARG_BITS-1:0]   arg,
   output logic [ROOT_BITS-1:0]  root,
   output sar_pkg::sqrt_stat_type stat
);
   import sar_pkg::*;

   localparam int REM_BITS = ROOT_BITS + 2;
   localparam int CNT_W    = $clog2(ROOT_BITS + 1);

   logic [RAD_BITS-1:0]  rad_ff, rad_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [REM_BITS-1:0]  rem_sh;
   logic [REM_BITS-1:0]  trial;
   logic                 fits;

   // one root bit per cycle: shift in two radicand bits, try 4q+1
   assign rem_sh = {rem_ff[REM_BITS-3:0], rad_ff[RAD_BITS-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         rad_in = {rad_ff[RAD_BITS-3:0], 2'b00};
         if (fits) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         rad_in  = RAD_BITS'({arg, 32'h0});
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_BITS);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root      = root_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
